/* rtl/art_pkg.sv */
// ----------------------------------------------------------------------------
// art_pkg
// Shared types and constants for the address region table.
// ----------------------------------------------------------------------------
package art_pkg;

  localparam int ADDR_W          = 64;
  localparam int FLAG_W          = 32;
  localparam int STATUS_W        = 2;
  localparam int MAX_REGIONS_DEF = 16;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_FIND = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_RANGE = 2'd1,
    STATUS_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    logic [FLAG_W-1:0] flags;
  } region_t;

  typedef struct packed {
    logic              active;
    logic              found;
    logic [ADDR_W-1:0] addr;
    region_t           region;
  } search_t;

endpackage

/* rtl/art_in_if.sv */
// ----------------------------------------------------------------------------
// art_in_if
// Request channel: add or find item with valid/ready handshake.
// ----------------------------------------------------------------------------
interface art_in_if;
  logic                      valid;
  logic                      ready;
  logic                      op;
  logic [art_pkg::ADDR_W-1:0] region_start_in;
  logic [art_pkg::ADDR_W-1:0] region_end_in;
  logic [art_pkg::FLAG_W-1:0] region_flags_in;
  logic [art_pkg::ADDR_W-1:0] probe_addr;

  modport source (
    output valid, op, region_start_in, region_end_in, region_flags_in, probe_addr,
    input  ready
  );
  modport sink (
    input  valid, op, region_start_in, region_end_in, region_flags_in, probe_addr,
    output ready
  );
endinterface

/* rtl/art_out_if.sv */
// ----------------------------------------------------------------------------
// art_out_if
// Response channel: one result item per request item.
// ----------------------------------------------------------------------------
interface art_out_if;
  logic                         valid;
  logic                         ready;
  logic [art_pkg::STATUS_W-1:0] status;
  logic                         hit;
  logic [art_pkg::ADDR_W-1:0]   hit_start;
  logic [art_pkg::ADDR_W-1:0]   hit_end;
  logic [art_pkg::FLAG_W-1:0]   hit_flags;

  modport source (
    output valid, status, hit, hit_start, hit_end, hit_flags,
    input  ready
  );
  modport sink (
    input  valid, status, hit, hit_start, hit_end, hit_flags,
    output ready
  );
endinterface

/* rtl/address_region_table_top.sv */
// ----------------------------------------------------------------------------
// address_region_table_top
// Region table built as a row of cells, newest region in cell 0.
//
//   channel  dir  content
//   req      in   op, region_start_in, region_end_in, region_flags_in, probe_addr
//   rsp      out  status, hit, hit_start, hit_end, hit_flags
//
// An add item's result is registered at acceptance.
// A find item walks the cell row one cell per cycle, through the whole cell chain
// to the result register. One item is in work at a time.
// Reset empties the table at once. A stalled response holds new requests off.
// ----------------------------------------------------------------------------
module address_region_table_top #(
  parameter int MAX_REGIONS = art_pkg::MAX_REGIONS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  art_in_if.sink    req,
  art_out_if.source rsp
);

  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  logic [CNT_W-1:0]  count;
  logic              busy;
  logic              out_valid;
  logic [art_pkg::STATUS_W-1:0] out_status;
  logic              out_hit;
  art_pkg::region_t  out_region;

  logic              accept;
  logic              is_add;
  logic              bad_range;
  logic              full;
  logic              shift_en;

  art_pkg::region_t  chain_region [MAX_REGIONS+1];
  art_pkg::search_t  chain_srch   [MAX_REGIONS+1];
  art_pkg::search_t  exit_srch;

  assign req.ready = !busy && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;
  assign is_add    = (req.op == art_pkg::OP_ADD);
  assign bad_range = (req.region_start_in >= req.region_end_in);
  assign full      = (count == CNT_W'(MAX_REGIONS));
  assign shift_en  = accept && is_add && !bad_range && !full;

  assign chain_region[0] = {req.region_start_in, req.region_end_in, req.region_flags_in};
  assign chain_srch[0]   = {accept && !is_add, 1'b0, req.probe_addr,
                            {$bits(art_pkg::region_t){1'b0}}};

  for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
    art_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .shift_en   (shift_en),
      .valid      (CNT_W'(i) < count),
      .region_in  (chain_region[i]),
      .region_out (chain_region[i+1]),
      .srch_in    (chain_srch[i]),
      .srch_out   (chain_srch[i+1])
    );
  end

  assign exit_srch = chain_srch[MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
    end else begin
      if (shift_en) begin
        count <= count + CNT_W'(1);
      end
      if (accept && !is_add) begin
        busy <= 1'b1;
      end else if (exit_srch.active) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && is_add) begin
      out_valid <= 1'b1;
    end else if (exit_srch.active) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_add) begin
      out_hit    <= 1'b0;
      out_region <= '0;
      if (bad_range) begin
        out_status <= art_pkg::STATUS_BAD_RANGE;
      end else if (full) begin
        out_status <= art_pkg::STATUS_FULL;
      end else begin
        out_status <= art_pkg::STATUS_OK;
      end
    end else if (exit_srch.active) begin
      out_status <= art_pkg::STATUS_OK;
      out_hit    <= exit_srch.found;
      out_region <= exit_srch.region;
    end
  end

  assign rsp.valid     = out_valid;
  assign rsp.status    = out_status;
  assign rsp.hit       = out_hit;
  assign rsp.hit_start = out_region.start;
  assign rsp.hit_end   = out_region.stop;
  assign rsp.hit_flags = out_region.flags;

endmodule

/* rtl/art_cell.sv */
// ----------------------------------------------------------------------------
// art_cell
// One table entry: holds a region, shifts it on add, checks a passing probe.
// ----------------------------------------------------------------------------
module art_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              shift_en,
  input  logic              valid,
  input  art_pkg::region_t  region_in,
  output art_pkg::region_t  region_out,
  input  art_pkg::search_t  srch_in,
  output art_pkg::search_t  srch_out
);

  art_pkg::region_t region;
  art_pkg::search_t srch;
  art_pkg::search_t srch_next;
  logic             match;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      region <= region_in;
    end
  end

  assign match = valid && !srch_in.found &&
                 (srch_in.addr >= region.start) && (srch_in.addr < region.stop);

  always_comb begin
    srch_next = srch_in;
    if (match) begin
      srch_next.found  = 1'b1;
      srch_next.region = region;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srch.active <= 1'b0;
    end else begin
      srch.active <= srch_in.active;
    end
    srch.found  <= srch_next.found;
    srch.addr   <= srch_next.addr;
    srch.region <= srch_next.region;
  end

  assign region_out = region;
  assign srch_out   = srch;

endmodule

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for address_region_table_top. A local copy of the
// region table predicts every response, and responses are checked in order.
// Directed items cover rejected ranges, lookups on an empty table, edge
// addresses and overlapping regions. Random items follow, with random gaps
// and response stalls and one long response hold-off. A last pass fills the
// table and checks that full-table adds are refused.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import art_pkg::*;

  localparam int                MAX_REGIONS  = MAX_REGIONS_DEF;
  localparam int                RANDOM_ITEMS = 2000;
  localparam int                IDLE_LIMIT   = 2000;
  localparam int                HOLD_CYCLES  = 400;
  localparam logic [ADDR_W-1:0] ADDR_MAX     = '1;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    logic [FLAG_W-1:0] flags;
    logic [ADDR_W-1:0] addr;
  } request_t;

  typedef struct packed {
    status_t           status;
    logic              hit;
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] stop;
    logic [FLAG_W-1:0] flags;
  } response_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  art_in_if  req_if ();
  art_out_if rsp_if ();

  address_region_table_top #(
    .MAX_REGIONS(MAX_REGIONS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if)
  );

  region_t   regions [MAX_REGIONS];
  int        region_count;
  response_t awaited_responses [$];
  int        error_count;
  bit        gaps_on;
  bit        stalls_on;
  bit        long_hold;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic response_t table_response(input request_t it);
    response_t r;
    r = '0;
    if (it.op == OP_ADD) begin
      if (it.start >= it.stop) begin
        r.status = STATUS_BAD_RANGE;
      end else if (region_count >= MAX_REGIONS) begin
        r.status = STATUS_FULL;
      end else begin
        regions[region_count] = '{start: it.start, stop: it.stop, flags: it.flags};
        region_count++;
      end
    end else begin
      // newest entry wins: later matches override earlier ones
      for (int k = 0; k < region_count; k++) begin
        if (it.addr >= regions[k].start && it.addr < regions[k].stop) begin
          r.hit   = 1'b1;
          r.start = regions[k].start;
          r.stop  = regions[k].stop;
          r.flags = regions[k].flags;
        end
      end
    end
    return r;
  endfunction

  task automatic note_error(input string what, input response_t want, input response_t got);
    error_count++;
    if (error_count <= 10) begin
      $display("%0t %s: want st=%0d hit=%0b start=%h stop=%h flags=%h", $time, what,
               want.status, want.hit, want.start, want.stop, want.flags);
      $display("%0t %s:  got st=%0d hit=%0b start=%h stop=%h flags=%h", $time, what,
               got.status, got.hit, got.start, got.stop, got.flags);
    end
  endtask

  always @(posedge clk) begin
    response_t got;
    response_t want;
    request_t  seen;
    if (!rst) begin
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = status_t'(rsp_if.status);
        got.hit    = rsp_if.hit;
        got.start  = rsp_if.hit_start;
        got.stop   = rsp_if.hit_end;
        got.flags  = rsp_if.hit_flags;
        if (awaited_responses.size() == 0) begin
          note_error("unexpected item", '0, got);
        end else begin
          want = awaited_responses.pop_front();
          if (got.status !== want.status || got.hit !== want.hit ||
              got.start !== want.start || got.stop !== want.stop ||
              got.flags !== want.flags) begin
            note_error("mismatch", want, got);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        seen.op    = op_t'(req_if.op);
        seen.start = req_if.region_start_in;
        seen.stop  = req_if.region_end_in;
        seen.flags = req_if.region_flags_in;
        seen.addr  = req_if.probe_addr;
        awaited_responses.push_back(table_response(seen));
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else if (stalls_on && !rst && $urandom_range(0, 5) == 0) begin
        rsp_if.ready = 1'b0;
        repeat ($urandom_range(1, 17) - 1) @(negedge clk);
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_item(input request_t it);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    req_if.valid           = 1'b1;
    req_if.op              = it.op;
    req_if.region_start_in = it.start;
    req_if.region_end_in   = it.stop;
    req_if.region_flags_in = it.flags;
    req_if.probe_addr      = it.addr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_add(input logic [ADDR_W-1:0] start, input logic [ADDR_W-1:0] stop,
                          input logic [FLAG_W-1:0] flags);
    send_item('{OP_ADD, start, stop, flags, rand_addr()});
  endtask

  task automatic send_find(input logic [ADDR_W-1:0] addr);
    send_item('{OP_FIND, rand_addr(), rand_addr(), $urandom, addr});
  endtask

  task automatic pick_region(output logic [ADDR_W-1:0] start, output logic [ADDR_W-1:0] stop);
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    a = rand_addr();
    b = rand_addr();
    case ($urandom_range(0, 3))
      0: begin
        start = (a > ADDR_MAX - 16) ? ADDR_MAX - 16 : a;
        stop  = start + $urandom_range(1, 16);
      end
      1: begin
        if (a == b) b = a + 1;
        start = (a < b) ? a : b;
        stop  = (a < b) ? b : a;
      end
      2: begin
        start = $urandom_range(0, 4095);
        stop  = start + $urandom_range(1, 65536);
      end
      default: begin
        start = ADDR_MAX - 1 - $urandom;
        stop  = ADDR_MAX;
      end
    endcase
  endtask

  function automatic logic [ADDR_W-1:0] pick_probe();
    region_t r;
    if (region_count == 0 || $urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 5))
        0:       return '0;
        1:       return ADDR_MAX;
        default: return rand_addr();
      endcase
    end
    r = regions[$urandom_range(0, region_count - 1)];
    case ($urandom_range(0, 5))
      0:       return r.start;
      1:       return r.stop - 1;
      2:       return r.stop;
      3:       return r.start - 1;
      default: return r.start + rand_addr() % (r.stop - r.start);
    endcase
  endfunction

  task automatic test_bad_ranges();
    send_add('0, '0, '1);
    send_add(64'h2000, 64'h1000, 32'h1234_5678);
    send_add(ADDR_MAX, '0, '1);
    send_add(ADDR_MAX, ADDR_MAX, '0);
  endtask

  task automatic test_empty_table();
    send_find('0);
    send_find(ADDR_MAX);
    send_find(rand_addr());
  endtask

  task automatic test_edge_regions();
    send_add('0, 64'd1, '0);
    send_add(ADDR_MAX - 1, ADDR_MAX, '1);
    send_find('0);
    send_find(64'd1);
    send_find(ADDR_MAX - 1);
    send_find(ADDR_MAX);
  endtask

  task automatic test_overlap();
    send_add(64'h1000, 64'h2000, 32'hAAAA_5555);
    send_add(64'h1800, 64'h3000, 32'h5555_AAAA);
    send_find(64'h17FF);
    send_find(64'h1800);
    send_find(64'h1FFF);
    send_find(64'h2FFF);
    send_find(64'h3000);
    send_find(64'h0FFF);
  endtask

  task automatic test_random_traffic();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      gaps_on   = ((i / 200) % 4) < 2;
      stalls_on = ((i / 200) % 2) == 0;
      if (i == RANDOM_ITEMS / 2) long_hold = 1'b1;
      if ($urandom_range(0, 19) == 0) begin
        if (region_count < MAX_REGIONS - 1 && $urandom_range(0, 9) == 0) begin
          pick_region(a, b);
          send_add(a, b, $urandom);
        end else begin
          a = rand_addr();
          b = ($urandom_range(0, 3) == 0) ? a : rand_addr();
          send_add((a >= b) ? a : b, (a >= b) ? b : a, $urandom);
        end
      end else begin
        send_find(pick_probe());
      end
    end
  endtask

  task automatic test_full_table();
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] b;
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    while (region_count < MAX_REGIONS - 1) begin
      pick_region(a, b);
      send_add(a, b, $urandom);
      send_find(pick_probe());
    end
    send_add('0, ADDR_MAX, 32'hC0DE_F00D);
    send_find('0);
    send_find(ADDR_MAX);
    send_find(ADDR_MAX - 1);
    repeat (8) send_find(pick_probe());
    send_add('0, 64'd1, '1);
    send_add(64'h10, 64'h20, '0);
    send_add(ADDR_MAX, '0, '1);
    send_add(64'h5, 64'h5, '0);
    repeat (8) send_find(pick_probe());
  endtask

  initial begin
    req_if.valid           = 1'b0;
    req_if.op              = OP_ADD;
    req_if.region_start_in = '0;
    req_if.region_end_in   = '0;
    req_if.region_flags_in = '0;
    req_if.probe_addr      = '0;
    error_count  = 0;
    region_count = 0;
    gaps_on      = 1'b1;
    stalls_on    = 1'b1;
    long_hold    = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_bad_ranges();
    test_empty_table();
    test_edge_regions();
    test_overlap();
    test_random_traffic();
    test_full_table();

    req_if.valid = 1'b0;
    while (awaited_responses.size() != 0) @(posedge clk);
    repeat (MAX_REGIONS + 8) @(posedge clk);
    error_count += awaited_responses.size();
    if (error_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
